@@ rtl/lcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared widths, costs, reset values and the cell control bundle for the
// LRU cache cost counter.
// ----------------------------------------------------------------------------
package lcc_pkg;

  // Default sizing of the LRU stack
  localparam int MAX_ENTRIES_DEF = 32;
  localparam int KEY_BITS_DEF    = 64;

  // Fixed field widths
  localparam int CITY_KEY_W = 64;
  localparam int CFG_W      = 6;
  localparam int COST_W     = 24;

  // Register reset and cost constants
  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(3);
  localparam logic [COST_W:0]   HIT_COST  = (COST_W+1)'(1);
  localparam logic [COST_W:0]   MISS_COST = (COST_W+1)'(5);
  localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};

  // Broadcast control for every cell of the stack
  typedef struct packed {
    logic accept;    // request beat taken this cycle
    logic new_run;   // empty the stack before the lookup
    logic cache_on;  // configured size is not zero
    logic hit;       // key found somewhere in the stack
  } lcc_ctl_t;

endpackage

@@ rtl/lcc_ifs.sv @@
// ----------------------------------------------------------------------------
// lcc_ifs
// Valid/ready channels of the LRU cache cost counter: request, result and
// size configuration.
// ----------------------------------------------------------------------------
interface lcc_req_if;
  logic                             valid;
  logic                             ready;
  logic [lcc_pkg::CITY_KEY_W-1:0]   city_key;
  logic                             new_run;

  modport source (output valid, output city_key, output new_run, input ready);
  modport sink   (input valid, input city_key, input new_run, output ready);
endinterface

interface lcc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lcc_pkg::COST_W-1:0]   total_cost;

  modport source (output valid, output hit, output total_cost, input ready);
  modport sink   (input valid, input hit, input total_cost, output ready);
endinterface

interface lcc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lcc_pkg::CFG_W-1:0]    cache_entries;

  modport source (output valid, output cache_entries, input ready);
  modport sink   (input valid, input cache_entries, output ready);
endinterface

@@ rtl/lru_cache_cost_counter.sv @@
// ----------------------------------------------------------------------------
// lru_cache_cost_counter
// Fully associative LRU cache scorer built as a shifting stack of cells.
// ----------------------------------------------------------------------------
// One request beat is taken per clock and its result beat appears on the
// cycle after; a result waiting in the output register holds off the next
// request only while the sink stalls. Every cell compares its key in
// parallel, a match flag ripples down the row of MAX_ENTRIES cells to select
// the shifting places, and the whole stack moves in the same cycle, so that
// row sets the clock period. A hit costs 1, a miss costs 5, and the total
// saturates at its 24-bit maximum. Only the low KEY_BITS bits of a key take
// part. A size above MAX_ENTRIES acts as MAX_ENTRIES; a size of zero makes
// every request a miss. Size writes are taken at any time and belong between
// runs of requests.
// ----------------------------------------------------------------------------
module lru_cache_cost_counter #(
  parameter int MAX_ENTRIES = lcc_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = lcc_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lcc_req_if.sink     in_ch,
  lcc_rsp_if.source   out_ch,
  lcc_cfg_if.sink     cfg_ch
);

  logic [lcc_pkg::CFG_W-1:0]   cfg_entries_r;
  logic [lcc_pkg::COST_W-1:0]  cost_r;
  logic [lcc_pkg::COST_W-1:0]  cost_nxt;
  logic                        out_valid_r;
  logic                        out_hit_r;

  lcc_pkg::lcc_ctl_t           ctl;
  logic [KEY_BITS-1:0]         req_key;
  logic [KEY_BITS-1:0]         cell_key   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]      cell_valid;
  logic [MAX_ENTRIES-1:0]      cell_valid_q;
  logic [MAX_ENTRIES:0]        seen;
  logic [MAX_ENTRIES-1:0]      lim_ok;
  logic [lcc_pkg::COST_W-1:0]  cost_base;
  logic [lcc_pkg::COST_W:0]    cost_sum;

  // Size register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= lcc_pkg::CFG_RESET;
    end else if (cfg_ch.valid) begin
      cfg_entries_r <= cfg_ch.cache_entries;
    end
  end

  // Request handshake: free the input once the result register drains
  assign in_ch.ready  = ~out_valid_r | out_ch.ready;
  assign req_key      = in_ch.city_key[KEY_BITS-1:0];

  assign ctl.accept   = in_ch.valid & in_ch.ready;
  assign ctl.new_run  = in_ch.new_run;
  assign ctl.cache_on = (cfg_entries_r != '0);
  assign ctl.hit      = seen[MAX_ENTRIES];

  // Row of stack cells, most recent first
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign lim_ok[i] = (32'(i) < 32'(cfg_entries_r));

    if (i == 0) begin : g_head
      lcc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .req_key    (req_key),
        .lim_ok     (lim_ok[i]),
        .prev_key   (req_key),
        .prev_valid (1'b1),
        .seen_in    (seen[i]),
        .key_out    (cell_key[i]),
        .valid_out  (cell_valid[i]),
        .seen_out   (seen[i+1]),
        .valid_q    (cell_valid_q[i])
      );
    end else begin : g_body
      lcc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .req_key    (req_key),
        .lim_ok     (lim_ok[i]),
        .prev_key   (cell_key[i-1]),
        .prev_valid (cell_valid[i-1]),
        .seen_in    (seen[i]),
        .key_out    (cell_key[i]),
        .valid_out  (cell_valid[i]),
        .seen_out   (seen[i+1]),
        .valid_q    (cell_valid_q[i])
      );
    end
  end

  // Saturating cost total
  assign cost_base = in_ch.new_run ? '0 : cost_r;
  assign cost_sum  = {1'b0, cost_base} +
                     (ctl.hit ? lcc_pkg::HIT_COST : lcc_pkg::MISS_COST);
  assign cost_nxt  = cost_sum[lcc_pkg::COST_W] ? lcc_pkg::COST_MAX
                                               : cost_sum[lcc_pkg::COST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
    end else if (ctl.accept) begin
      cost_r <= cost_nxt;
    end
  end

  // Result register: load on accept, drop once the sink takes the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      out_hit_r <= ctl.hit;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.total_cost = cost_r;

  // Valid places always form an unbroken run from the most recent place
  a_valid_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid_q & (cell_valid_q + MAX_ENTRIES'(1))) == '0)
    else $error("LRU stack valid bits are not contiguous");

  // No hit can come out of a disabled cache
  a_no_hit_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept && !ctl.cache_on |=> !out_hit_r)
    else $error("hit reported with cache size zero");

  // A miss leaves no more entries than the configured size
  a_miss_trims: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept && !ctl.hit |=>
      32'($countones(cell_valid_q)) <= 32'($past(cfg_entries_r)))
    else $error("occupancy above configured size after a miss");

  // Within a run the cost total never falls
  a_cost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept && !in_ch.new_run |=> cost_r >= $past(cost_r))
    else $error("cost total decreased within a run");

  // A taken request always produces a result beat next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept |=> out_valid_r)
    else $error("accepted request produced no result beat");

endmodule

@@ rtl/lcc_cell.sv @@
// ----------------------------------------------------------------------------
// lcc_cell
// One place of the LRU stack: holds a key and its valid bit, compares the
// key against the request and takes its younger neighbor's key on a shift.
// ----------------------------------------------------------------------------
module lcc_cell #(
  parameter int KEY_BITS = lcc_pkg::KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcc_pkg::lcc_ctl_t     ctl,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic                  lim_ok,      // this place lies inside the size
  input  logic [KEY_BITS-1:0]   prev_key,    // younger neighbor (or request)
  input  logic                  prev_valid,  // younger neighbor holds a key
  input  logic                  seen_in,     // match found in a younger place
  output logic [KEY_BITS-1:0]   key_out,
  output logic                  valid_out,
  output logic                  seen_out,
  output logic                  valid_q
);

  logic [KEY_BITS-1:0] key_r;
  logic                valid_r;
  logic                valid_eff;
  logic                match;
  logic                new_valid;
  logic                take;

  // Look up: a new run empties the place before the compare
  assign valid_eff = valid_r & ~ctl.new_run;
  assign match     = valid_eff & ctl.cache_on & (key_r == req_key);
  assign seen_out  = seen_in | match;

  // Shift decision: on a hit every place up to the match moves down,
  // on a miss every place that stays inside the size moves down
  assign new_valid = lim_ok & prev_valid;
  assign take      = ctl.hit ? ~seen_in : new_valid;

  // Hold the valid bit; only a miss changes occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.accept && !ctl.hit) begin
      valid_r <= new_valid;
    end
  end

  // Advance the key from the younger neighbor
  always_ff @(posedge clk) begin
    if (ctl.accept && take) begin
      key_r <= prev_key;
    end
  end

  assign key_out   = key_r;
  assign valid_out = valid_eff;
  assign valid_q   = valid_r;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU cache cost counter. A shadow LRU stack
// scores every request beat taken by the block, and each result beat is
// checked against the oldest pending score. Directed tests cover the default
// size, size zero, a size shrunk within a run and a size above capacity.
// Random runs of requests then sweep several sizes under varying source and
// sink stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int          MAX_ENTRIES = lcc_pkg::MAX_ENTRIES_DEF;
  localparam int          KEY_BITS    = lcc_pkg::KEY_BITS_DEF;
  localparam logic [63:0] KEY_MASK    = {64{1'b1}} >> (64 - KEY_BITS);
  localparam int          POOL_SIZE   = 72;
  localparam int          CYCLE_LIMIT = 200_000;
  localparam int          RUN_ITEMS   = 105;

  typedef struct {
    logic                       hit;
    logic [lcc_pkg::COST_W-1:0] total_cost;
  } score_t;

  logic clk;
  logic rst_n;

  lcc_req_if in_if ();
  lcc_rsp_if out_if ();
  lcc_cfg_if cfg_if ();

  lru_cache_cost_counter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow LRU stack, most recent first
  logic [63:0]                lru_keys [MAX_ENTRIES];
  int unsigned                lru_fill;
  logic [lcc_pkg::COST_W-1:0] cost_sum;
  logic [lcc_pkg::CFG_W-1:0]  cache_size;

  score_t      expected_scores [$];
  logic [63:0] key_pool [POOL_SIZE];
  int          mismatch_count;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;

  // Toggle the clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Score one accepted request on the shadow stack and queue its result
  function automatic void score_request(input logic [63:0] raw_key, input logic run_start);
    logic [63:0]              key;
    int unsigned              limit;
    int unsigned              pos;
    int unsigned              fill_next;
    int unsigned              i;
    logic                     found;
    logic [lcc_pkg::COST_W:0] sum;
    score_t                   s;
    key   = raw_key & KEY_MASK;
    limit = (cache_size > MAX_ENTRIES) ? MAX_ENTRIES : cache_size;
    found = 1'b0;
    pos   = 0;
    if (run_start) begin
      lru_fill = 0;
      cost_sum = '0;
    end
    if (lru_fill > MAX_ENTRIES) lru_fill = MAX_ENTRIES;
    if (limit > 0) begin
      for (i = 0; i < lru_fill; i++) begin
        if (!found && lru_keys[i] == key) begin
          found = 1'b1;
          pos   = i;
        end
      end
    end
    if (found) begin
      for (i = pos; i > 0; i--) lru_keys[i] = lru_keys[i-1];
      lru_keys[0] = key;
      sum = {1'b0, cost_sum} + lcc_pkg::HIT_COST;
    end else begin
      if (limit == 0) begin
        lru_fill = 0;
      end else begin
        fill_next = lru_fill + 1;
        if (fill_next > limit) fill_next = limit;
        for (i = fill_next - 1; i > 0; i--) lru_keys[i] = lru_keys[i-1];
        lru_keys[0] = key;
        lru_fill = fill_next;
      end
      sum = {1'b0, cost_sum} + lcc_pkg::MISS_COST;
    end
    cost_sum = (sum > {1'b0, lcc_pkg::COST_MAX}) ? lcc_pkg::COST_MAX
                                                 : sum[lcc_pkg::COST_W-1:0];
    s.hit        = found;
    s.total_cost = cost_sum;
    expected_scores.insert(expected_scores.size(), s);
  endfunction

  // Pick a key: mostly from the live part of the pool, some fresh, some near misses
  function automatic logic [63:0] pick_key(input int span);
    int r;
    r = $urandom_range(99);
    if (r < 75) return key_pool[$urandom_range(span - 1)];
    else if (r < 90) return {$urandom, $urandom};
    else return key_pool[$urandom_range(span - 1)] ^ (64'd1 << $urandom_range(63));
  endfunction

  // Send one request beat, with random gaps ahead of it
  task automatic send_request(input logic [63:0] key, input logic run_start);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.city_key <= key;
    in_if.new_run  <= run_start;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    score_request(key, run_start);
  endtask

  // Hold off requests until every pending score has come back
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the cache size while the block is idle
  task automatic write_cache_size(input logic [lcc_pkg::CFG_W-1:0] size);
    drain_results();
    @(negedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.cache_entries <= size;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cache_size = size;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Default size of three: eviction of the oldest, hit on the oldest, key extremes
  task automatic test_default_size();
    send_request(64'd0, 1'b1);
    send_request({64{1'b1}}, 1'b0);
    send_request(key_pool[2], 1'b0);
    send_request(64'd0, 1'b0);
    send_request(key_pool[3], 1'b0);
    send_request({64{1'b1}}, 1'b0);
    send_request({64{1'b1}}, 1'b0);
    send_request(key_pool[2], 1'b1);
  endtask

  // Size zero: repeated keys still miss
  task automatic test_size_zero();
    write_cache_size(lcc_pkg::CFG_W'(0));
    send_request(key_pool[2], 1'b1);
    send_request(key_pool[2], 1'b0);
    send_request(key_pool[2], 1'b0);
  endtask

  // Shrink within a run: old entries still hit until the next miss trims them
  task automatic test_size_shrink();
    int i;
    write_cache_size(lcc_pkg::CFG_W'(MAX_ENTRIES));
    for (i = 2; i < 8; i++) send_request(key_pool[i], i == 2);
    write_cache_size(lcc_pkg::CFG_W'(2));
    send_request(key_pool[2], 1'b0);
    send_request(key_pool[8], 1'b0);
    send_request(key_pool[3], 1'b0);
    write_cache_size(lcc_pkg::CFG_W'(0));
    send_request(key_pool[8], 1'b0);
  endtask

  // Size above capacity acts as full capacity
  task automatic test_size_above_capacity();
    write_cache_size({lcc_pkg::CFG_W{1'b1}});
    send_request(key_pool[4], 1'b1);
    send_request(key_pool[5], 1'b0);
    send_request(key_pool[4], 1'b0);
  endtask

  // Random runs of requests at three sizes under one stall mix
  task automatic test_random_runs(input int tx_pct, input int rx_pct,
                                  input logic [lcc_pkg::CFG_W-1:0] s0,
                                  input logic [lcc_pkg::CFG_W-1:0] s1,
                                  input logic [lcc_pkg::CFG_W-1:0] s2);
    logic [lcc_pkg::CFG_W-1:0] sizes [3];
    int k;
    int n;
    int j;
    int run_len;
    int span;
    int limit;
    logic broken;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sizes[0] = s0;
    sizes[1] = s1;
    sizes[2] = s2;
    for (k = 0; k < 3; k++) begin
      write_cache_size(sizes[k]);
      limit = (sizes[k] > MAX_ENTRIES) ? MAX_ENTRIES : sizes[k];
      span  = (limit + 4 > POOL_SIZE) ? POOL_SIZE : limit + 4;
      n = 0;
      while (n < RUN_ITEMS) begin
        run_len = $urandom_range(60, 8);
        broken  = ($urandom_range(19) == 0);
        for (j = 0; j < run_len && n < RUN_ITEMS; j++) begin
          send_request(pick_key(span), ((j == 0) && !broken) || ($urandom_range(99) < 2));
          n++;
          if ($urandom_range(199) == 0) drain_results();
        end
      end
    end
  endtask

  // Stall the result sink at random
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check each result beat against the oldest pending score
  always @(posedge clk) begin
    score_t exp_s;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_scores.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with no pending score: expected none, actual hit %0b cost %0d",
                 $time, out_if.hit, out_if.total_cost);
      end else begin
        exp_s = expected_scores[0];
        expected_scores.delete(0);
        if (out_if.hit !== exp_s.hit || out_if.total_cost !== exp_s.total_cost) begin
          mismatch_count++;
          $display("%0t: mismatch hit expected %0b actual %0b, cost expected %0d actual %0d",
                   $time, exp_s.hit, out_if.hit, exp_s.total_cost, out_if.total_cost);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reset, then run the tests in turn
  initial begin
    int i;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.city_key       = '0;
    in_if.new_run        = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.cache_entries = '0;
    mismatch_count       = 0;
    cycle_count          = 0;
    tx_idle_pct          = 23;
    rx_idle_pct          = 58;
    lru_fill             = 0;
    cost_sum             = '0;
    cache_size           = lcc_pkg::CFG_RESET;
    for (i = 0; i < MAX_ENTRIES; i++) lru_keys[i] = '0;
    key_pool[0] = '0;
    key_pool[1] = {64{1'b1}};
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_size();
    test_size_zero();
    test_size_shrink();
    test_size_above_capacity();
    test_random_runs(23, 58, lcc_pkg::CFG_W'(1), lcc_pkg::CFG_W'(MAX_ENTRIES),
                     lcc_pkg::CFG_W'($urandom_range(31, 4)));
    test_random_runs(58, 23, lcc_pkg::CFG_W'(0), lcc_pkg::CFG_W'(2), {lcc_pkg::CFG_W{1'b1}});
    test_random_runs(0, 0, lcc_pkg::CFG_W'(3), lcc_pkg::CFG_W'(MAX_ENTRIES + 1),
                     lcc_pkg::CFG_W'($urandom_range(40, 1)));

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
